// ===== rtl/core/imu_frm_pkg.sv =====
`default_nettype none

package imu_frm_pkg;

    // frame framing bytes
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // byte count in front of the checksum byte
    localparam int unsigned SUM_LEN   = 10;
    localparam int unsigned CNT_W     = 4;
    localparam logic [CNT_W-1:0] CNT_IDLE  = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_TYPE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_CHECK = CNT_W'(SUM_LEN);

    // data bytes per frame (four little-endian words)
    localparam int unsigned DATA_BYTES = 8;

    // packed widths of the stream data buses
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 72;

    // one received byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/imu_frm_in_stage.sv =====
`default_nettype none

module imu_frm_in_stage
    import imu_frm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [IN_DATA_W-1:0] in_data,
    input  wire logic                 take,
    output byte_item_t                item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // register empties when the assembler takes the held byte
    assign in_ready   = !valid_reg || take;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // byte payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_data[7:0];
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/core/imu_frm_assembler.sv =====
`default_nettype none

module imu_frm_assembler
    import imu_frm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire byte_item_t            item,
    output logic                       take,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [1:0]       kind_reg;
    logic [7:0]       data_reg [DATA_BYTES];
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic             step;
    logic             is_type;
    logic             kind_load;
    logic             data_shift;
    logic             emit;
    logic [7:0]       b;

    assign b = item.data;

    // a checksum byte waits only while a finished result is still held
    assign take = !((cnt_reg == CNT_CHECK) && out_valid_reg && !out_ready);
    assign step = item.valid && take;

    assign is_type = (b == TYPE_ACC) || (b == TYPE_GYRO) || (b == TYPE_ANGLE);

    // frame sequencing on each consumed byte
    always_comb
    begin
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        kind_load  = 1'b0;
        data_shift = 1'b0;
        emit       = 1'b0;
        if (step)
        begin
            if (cnt_reg == CNT_IDLE || cnt_reg > CNT_CHECK)
            begin
                if (b == HDR_BYTE)
                begin
                    cnt_next = CNT_TYPE;
                    sum_next = b;
                end
                else
                begin
                    cnt_next = CNT_IDLE;
                    sum_next = 8'h00;
                end
            end
            else if (cnt_reg == CNT_TYPE)
            begin
                if (is_type)
                begin
                    kind_load = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    sum_next  = sum_reg + b;
                end
                else if (b == HDR_BYTE)
                begin
                    cnt_next = CNT_TYPE;
                    sum_next = b;
                end
                else
                begin
                    cnt_next = CNT_IDLE;
                    sum_next = 8'h00;
                end
            end
            else if (cnt_reg < CNT_CHECK)
            begin
                data_shift = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                sum_next   = sum_reg + b;
            end
            else
            begin
                // checksum byte closes the frame either way
                emit     = (b == sum_reg);
                cnt_next = CNT_IDLE;
                sum_next = 8'h00;
            end
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= CNT_IDLE;
            sum_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame byte store: kind plus a shift line of the eight data bytes
    always_ff @(posedge clk)
    begin
        if (kind_load)
        begin
            kind_reg <= 2'(b - TYPE_ACC);
        end
        if (data_shift)
        begin
            for (int i = 0; i < DATA_BYTES - 1; i++)
            begin
                data_reg[i] <= data_reg[i+1];
            end
            data_reg[DATA_BYTES-1] <= b;
        end
    end

    // result register, low byte of each word arrived first
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {6'b0,
                             data_reg[7], data_reg[6],
                             data_reg[5], data_reg[4],
                             data_reg[3], data_reg[2],
                             data_reg[1], data_reg[0],
                             kind_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/imu_uart_frame_parser.sv =====
// channel   dir  width  content
// s_axis    in   8      rx_byte [7:0]
// m_axis    out  72     frame_kind [1:0], axis_x [17:2], axis_y [33:18],
//                       axis_z [49:34], temperature [65:50], zero [71:66]
//
// one byte per cycle unless a checksum byte is stalled; a byte waits in the
// input register until taken, and a matching checksum byte registers a result.
// reset clears the byte counter, running sum and both valid flags.
// a waiting result stalls input only when a checksum byte is next to
// consume; all other bytes keep flowing under output backpressure.
`default_nettype none

module imu_uart_frame_parser
    import imu_frm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // rx_byte [7:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // frame_kind, axis_x, axis_y,
                                                      // axis_z, temperature, pad
);

    byte_item_t item;
    logic       take;

    // input register
    imu_frm_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .take     (take),
        .item     (item)
    );

    // frame assembly, checksum and result register
    imu_frm_assembler u_assembler (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .take      (take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
